// ===== rtl/lm_pkg.sv =====
`timescale 1ns / 1ps

package lm_pkg;

    // Q16 luminance weights; they sum to 65535.
    localparam logic [15:0] LUM_W_RED   = 16'd13926;
    localparam logic [15:0] LUM_W_GREEN = 16'd46884;
    localparam logic [15:0] LUM_W_BLUE  = 16'd4725;

    localparam logic [7:0] CHAN_MAX = 8'hFF;

    // Partial remainder and quotient of the restoring divider.
    typedef struct packed {
        logic [15:0] rem;
        logic [7:0]  quo;
    } t_div_st;

    // Un-premultiplied pixel handed from the divider to the luminance stages.
    typedef struct packed {
        logic       vld;
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] grn;
        logic [7:0] blu;
    } t_chan_px;

    // Four restoring division steps: quotient bits 7..4 when hi is set, else 3..0.
    function automatic t_div_st div_step4(t_div_st s, logic [7:0] a, logic hi);
        t_div_st     r;
        logic [15:0] dv;
        logic [2:0]  idx;
        begin
            r = s;
            for (int k = 0; k < 4; k++) begin
                idx = hi ? 3'(7 - k) : 3'(3 - k);
                dv  = 16'(a) << idx;
                if (r.rem >= dv) begin
                    r.rem      = r.rem - dv;
                    r.quo[idx] = 1'b1;
                end
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/lm_pixel_if.sv =====
`timescale 1ns / 1ps

interface lm_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

// ===== rtl/lm_mask_if.sv =====
`timescale 1ns / 1ps

interface lm_mask_if;
    logic        valid;
    logic        ready;
    logic [31:0] mask_word;

    modport source (output valid, output mask_word, input ready);
    modport sink   (input valid, input mask_word, output ready);
endinterface

// ===== rtl/lm_unpremul.sv =====
`timescale 1ns / 1ps

module lm_unpremul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [31:0]     i_pixel_word,
    output lm_pkg::t_chan_px o_px
);

    logic [7:0]  in_a;
    logic [7:0]  in_c [3];

    // Stage 1: dividends c*255 and saturation flags.
    logic             r_vld1;
    logic [7:0]       r_a1;
    logic [15:0]      r_dvd1 [3];
    logic [2:0]       r_sat1;

    // Stage 2: upper quotient bits.
    logic             r_vld2;
    logic [7:0]       r_a2;
    lm_pkg::t_div_st  r_st2 [3];
    logic [2:0]       r_sat2;

    // Stage 3: finished channels.
    logic             r_vld3;
    logic [7:0]       r_a3;
    logic [7:0]       r_ch3 [3];

    lm_pkg::t_div_st  n_st2 [3];
    lm_pkg::t_div_st  n_st3 [3];

    assign in_a    = i_pixel_word[31:24];
    assign in_c[0] = i_pixel_word[23:16];
    assign in_c[1] = i_pixel_word[15:8];
    assign in_c[2] = i_pixel_word[7:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_st2[i] = lm_pkg::div_step4('{rem: r_dvd1[i], quo: 8'h00}, r_a1, 1'b1);
            n_st3[i] = lm_pkg::div_step4(r_st2[i], r_a2, 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1 <= in_a;
            r_a2 <= r_a1;
            r_a3 <= r_a2;
            for (int i = 0; i < 3; i++) begin
                r_dvd1[i] <= {in_c[i], 8'h00} - 16'(in_c[i]);
                r_sat1[i] <= in_c[i] > in_a;
                r_st2[i]  <= n_st2[i];
                r_sat2[i] <= r_sat1[i];
                // A color above alpha would give a quotient past 255.
                r_ch3[i]  <= r_sat2[i] ? lm_pkg::CHAN_MAX : n_st3[i].quo;
            end
        end
    end

    assign o_px.vld   = r_vld3;
    assign o_px.alpha = r_a3;
    assign o_px.red   = r_ch3[0];
    assign o_px.grn   = r_ch3[1];
    assign o_px.blu   = r_ch3[2];

`ifndef ASSERT_OFF
    // After the upper four steps the remainder must be below the divisor times 16.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld2 && (r_a2 != 8'h00) && !r_sat2[0] |-> r_st2[0].rem < (16'(r_a2) << 4))
        else $error("upper divider steps left an oversized remainder");

    a_vld_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_vld2 |=> r_vld3)
        else $error("request lost between divider stages");
`endif

endmodule

// ===== rtl/lm_luma.sv =====
`timescale 1ns / 1ps

module lm_luma (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  lm_pkg::t_chan_px i_px,
    output logic             o_vld,
    output logic [31:0]      o_mask_word
);

    logic        r_vld1, r_vld2, r_vld3, r_vld4;
    logic [7:0]  r_a1, r_a2;
    logic [21:0] r_pr;
    logic [23:0] r_pg;
    logic [20:0] r_pb;
    logic [23:0] r_lum;
    logic [15:0] r_t;
    logic [7:0]  r_m;

    logic [23:0] n_pr, n_pg, n_pb;
    logic [31:0] n_prod;
    logic [16:0] n_t1;
    logic [16:0] n_s;

    assign n_pr   = 24'(i_px.red) * 24'(lm_pkg::LUM_W_RED);
    assign n_pg   = 24'(i_px.grn) * 24'(lm_pkg::LUM_W_GREEN);
    assign n_pb   = 24'(i_px.blu) * 24'(lm_pkg::LUM_W_BLUE);
    assign n_prod = 32'(r_lum) * 32'(r_a2);

    // floor(t / 255) for t below 65280, via a reciprocal with a carry correction.
    assign n_t1 = 17'(r_t) + 17'd1;
    assign n_s  = n_t1 + 17'(n_t1[16:8]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_px.vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1  <= i_px.alpha;
            r_pr  <= n_pr[21:0];
            r_pg  <= n_pg;
            r_pb  <= n_pb[20:0];
            r_a2  <= r_a1;
            r_lum <= 24'(r_pr) + r_pg + 24'(r_pb);
            // Dividing by 65536 is the upper half of the product.
            r_t   <= n_prod[31:16];
            r_m   <= n_s[15:8];
        end
    end

    assign o_vld       = r_vld4;
    assign o_mask_word = {r_m, 24'h000000};

`ifndef ASSERT_OFF
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 |-> $past(r_t) < 16'd65280 || !$past(i_en))
        else $error("scaled luminance out of range for the divide by 255");
`endif

endmodule

// ===== rtl/premultiplied_to_luminance_mask.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload            Width
// i_pixel   in   pixel_word (ARGB)  32
// o_mask    out  mask_word          32
//
// One pixel is accepted per cycle while the output is not stalled, through seven register
// stages: the dividend c*255, the two halves of the 8-bit divider, the weight products,
// their sum, the alpha product and the final divide by 255.
// Reset clears only the valid bits of the stages.
// A stalled output freezes the whole pipeline; no request is dropped or repeated.
module premultiplied_to_luminance_mask (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lm_pixel_if.sink    i_pixel,
    lm_mask_if.source   o_mask
);

    logic             en;
    logic             out_vld;
    lm_pkg::t_chan_px px;

    assign en            = !out_vld || o_mask.ready;
    assign i_pixel.ready = en;
    assign o_mask.valid  = out_vld;

    lm_unpremul u_unpremul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_vld        (i_pixel.valid),
        .i_pixel_word (i_pixel.pixel_word),
        .o_px         (px)
    );

    lm_luma u_luma (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_px         (px),
        .o_vld        (out_vld),
        .o_mask_word  (o_mask.mask_word)
    );

`ifndef ASSERT_OFF
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mask.valid && !o_mask.ready |-> !i_pixel.ready)
        else $error("request taken while the output is stalled");
`endif

endmodule
